/* rtl/core/isf_pkg.sv */
// ----------------------------------------------------------------------------
// isf_pkg: shared types and constants of the 3x3 smoothing filter
// Pixel type, register codes, register widths and their reset values.
// ----------------------------------------------------------------------------
package isf_pkg;

    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [CH_W-1:0]  chan_t;

    // defaults for the frame size limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

endpackage

/* rtl/core/isf_line_store.sv */
// ----------------------------------------------------------------------------
// isf_line_store: two row memories of the smoothing window
// Reads the previous two rows at one column into registers, and on write
// shifts the older row down and stores the new pixel; same-column overlap of
// a write and the following read is forwarded.
// ----------------------------------------------------------------------------
module isf_line_store #(
    parameter int MAX_WIDTH = isf_pkg::MAX_WIDTH_DEF,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic            aclk,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  isf_pkg::pixel_t wr_pixel,
    output isf_pkg::pixel_t rd_prev,
    output isf_pkg::pixel_t rd_prev2
);
    import isf_pkg::*;

    pixel_t row_prev_mem  [MAX_WIDTH];
    pixel_t row_prev2_mem [MAX_WIDTH];

    pixel_t mem_prev_reg, mem_prev2_reg;
    pixel_t fwd_prev_reg, fwd_prev2_reg;
    logic   fwd_sel_reg;

    // the older row takes what the item in flight read from the newer one
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_prev_mem[wr_addr]  <= wr_pixel;
            row_prev2_mem[wr_addr] <= rd_prev;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mem_prev_reg  <= row_prev_mem[rd_addr];
            mem_prev2_reg <= row_prev2_mem[rd_addr];
        end
    end

    // one-pixel rows: the read sees the write of the same cycle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_sel_reg   <= wr_en && (wr_addr == rd_addr);
            fwd_prev_reg  <= wr_pixel;
            fwd_prev2_reg <= rd_prev;
        end
    end

    assign rd_prev  = fwd_sel_reg ? fwd_prev_reg  : mem_prev_reg;
    assign rd_prev2 = fwd_sel_reg ? fwd_prev2_reg : mem_prev2_reg;

endmodule

/* rtl/core/image_3x3_smoothing_filter.sv */
// ----------------------------------------------------------------------------
// image_3x3_smoothing_filter: 3x3 smoothing over an RGB raster stream
// Usage:
//   s_ channel: one pixel per item, tdata = {blue, green, red} (red lowest),
//   tuser = flush. A flush item carries no pixel and drains one pending
//   result once the whole frame is in; otherwise it is dropped.
//   m_ channel: tdata = {blue, green, red}, tlast marks the final pixel of the
//   frame. Border pixels come out as zero.
//   cfg channel: index 0 = image width, 1 = image height; a write to either
//   restarts the frame. Write only while the block is idle. cfg_ready is always high.
// Timing:
//   One item per cycle sustained. Result k is written to the output register
//   after input k + W + 1 is accepted: the row memory read and stage 1 take
//   that input, then its window sum is registered. Remaining W + 1 results
//   follow flush items. Line store read-modify-write sets the rate.
//   s_tready drops only while a result waits in the output register and
//   m_tready is low; the pipeline then holds.
// Reset: frame positions and window clear, size goes to 640 x 480; row
//   memories are not cleared.
// ----------------------------------------------------------------------------
module image_3x3_smoothing_filter #(
    parameter int MAX_WIDTH  = isf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = isf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input pixels
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [isf_pkg::PIX_W-1:0]           s_tdata,  // red, green, blue
    input  logic                                s_tuser,  // flush
    // smoothed pixels
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [isf_pkg::PIX_W-1:0]           m_tdata,  // red, green, blue
    output logic                                m_tlast,  // frame_last
    // configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [isf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [isf_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import isf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);        // column index
    localparam int WW = $clog2(MAX_WIDTH + 1);    // width value
    localparam int RW = $clog2(MAX_HEIGHT + 1);   // row index, reaches H

    function automatic int unsigned eff_dim(input int unsigned v, input int unsigned maxv);
        int unsigned r;
        if (v == 0) r = 1;
        else if (v > maxv) r = maxv;
        else r = v;
        return r;
    endfunction

    logic [WW-1:0] width_reg;
    logic [RW-1:0] height_reg;
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [RW-1:0] in_row_reg, in_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;

    logic s_accept, cfg_accept, advance;
    logic received, is_pix, emit_pix, interior, flush_emit, last_out;

    // stage 1: row memory data returning
    logic          s1_valid_reg, s1_pix_reg, s1_emit_reg, s1_interior_reg, s1_last_reg;
    pixel_t        s1_px_reg;
    logic [CW-1:0] s1_addr_reg;

    pixel_t window_reg [6];   // col*3 + row, col 0 oldest
    pixel_t col_prev, col_prev2;
    pixel_t smooth_px;

    logic   out_valid_reg, out_last_reg;
    pixel_t out_data_reg;

    assign advance    = !out_valid_reg || m_tready;
    assign s_tready   = advance;
    assign s_accept   = s_tvalid && advance;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid;

    // frame position bookkeeping, decided when the item is taken
    assign received   = in_row_reg >= height_reg;
    assign is_pix     = !s_tuser && !received;
    assign emit_pix   = (in_row_reg >= RW'(2)) || (in_row_reg == RW'(1) && in_col_reg != '0);
    assign interior   = (out_row_reg >= RW'(1)) && ((out_row_reg + RW'(1)) < height_reg)
                     && (out_col_reg != '0) && ((WW'(out_col_reg) + WW'(1)) < width_reg);
    assign flush_emit = received && (out_row_reg < height_reg);
    assign last_out   = (out_row_reg == height_reg - RW'(1))
                     && (WW'(out_col_reg) == width_reg - WW'(1));

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (is_pix) begin
            if ((WW'(in_col_reg) + WW'(1)) >= width_reg) begin
                in_col_next = '0;
                in_row_next = in_row_reg + RW'(1);
            end else begin
                in_col_next = in_col_reg + CW'(1);
            end
        end
        if ((is_pix && emit_pix) || (flush_emit && !last_out)) begin
            if ((WW'(out_col_reg) + WW'(1)) >= width_reg) begin
                out_col_next = '0;
                out_row_next = out_row_reg + RW'(1);
            end else begin
                out_col_next = out_col_reg + CW'(1);
            end
        end else if (flush_emit && last_out) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= WW'(eff_dim(WIDTH_RESET, MAX_WIDTH));
            height_reg  <= RW'(eff_dim(HEIGHT_RESET, MAX_HEIGHT));
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (cfg_accept) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH: begin
                    width_reg   <= WW'(eff_dim(int'(cfg_data[WIDTH_REG_W-1:0]), MAX_WIDTH));
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                CFG_IMAGE_HEIGHT: begin
                    height_reg  <= RW'(eff_dim(int'(cfg_data[HEIGHT_REG_W-1:0]), MAX_HEIGHT));
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                default: ;
            endcase
        end else if (s_accept) begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_pix_reg      <= is_pix;
            s1_emit_reg     <= is_pix ? emit_pix : flush_emit;
            s1_interior_reg <= is_pix && interior;
            s1_last_reg     <= !is_pix && last_out;
            s1_px_reg       <= s_tdata;
            s1_addr_reg     <= in_col_reg;
        end
    end

    isf_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (CW)
    ) u_line_store (
        .aclk     (aclk),
        .rd_en    (s_accept && is_pix),
        .rd_addr  (in_col_reg),
        .wr_en    (advance && s1_valid_reg && s1_pix_reg),
        .wr_addr  (s1_addr_reg),
        .wr_pixel (s1_px_reg),
        .rd_prev  (col_prev),
        .rd_prev2 (col_prev2)
    );

    // center/2 + (eight neighbours)/16, per channel
    always_comb begin
        logic [CH_W+2:0] sum;
        smooth_px = '0;
        for (int k = 0; k < 3; k++) begin
            sum = (CH_W+3)'(window_reg[0][k*CH_W +: CH_W])
                + (CH_W+3)'(window_reg[1][k*CH_W +: CH_W])
                + (CH_W+3)'(window_reg[2][k*CH_W +: CH_W])
                + (CH_W+3)'(window_reg[3][k*CH_W +: CH_W])
                + (CH_W+3)'(window_reg[5][k*CH_W +: CH_W])
                + (CH_W+3)'(col_prev2[k*CH_W +: CH_W])
                + (CH_W+3)'(col_prev[k*CH_W +: CH_W])
                + (CH_W+3)'(s1_px_reg[k*CH_W +: CH_W]);
            smooth_px[k*CH_W +: CH_W] = (window_reg[4][k*CH_W +: CH_W] >> 1)
                                      + CH_W'(sum >> 4);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) window_reg[i] <= '0;
        end else if (advance && s1_valid_reg && s1_pix_reg) begin
            window_reg[0] <= window_reg[3];
            window_reg[1] <= window_reg[4];
            window_reg[2] <= window_reg[5];
            window_reg[3] <= col_prev2;
            window_reg[4] <= col_prev;
            window_reg[5] <= s1_px_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= s1_interior_reg ? smooth_px : '0;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* rtl/core/isf_checker.sv */
// ----------------------------------------------------------------------------
// isf_checker: port-level checks of the smoothing filter
// Output hold under stall, input back-pressure rule, reset and frame end.
// ----------------------------------------------------------------------------
module isf_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [isf_pkg::PIX_W-1:0] m_tdata,
    input logic                      m_tlast
);
    import isf_pkg::*;

    // a stalled item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // input is held off only by a waiting result
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output register state");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // final pixel of a frame is a corner, hence zero
    a_last_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == '0)
        else $error("frame end item not zero");

endmodule

bind image_3x3_smoothing_filter isf_checker u_isf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for image_3x3_smoothing_filter
// Streams RGB frames through the filter under random back-pressure and
// source gaps, predicts every smoothed pixel, border zero and end-of-frame
// marker from an internal model of the line stores and window, and compares
// each accepted output item against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import isf_pkg::*;

    localparam int          MAX_W        = MAX_WIDTH_DEF;
    localparam int          MAX_H        = MAX_HEIGHT_DEF;
    localparam int          RANDOM_ITEMS = 160;
    localparam int          SETTLE       = 8;
    localparam int unsigned CYCLE_LIMIT  = 500000;

    // spare register indexes, writes there are ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum int {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_NONE} idling_t;

    typedef struct packed {
        pixel_t data;
        logic   flush;
    } pixel_item_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  last;
    } smoothed_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [PIX_W-1:0]       s_tdata   = '0;    // red, green, blue
    logic                   s_tuser   = 1'b0;  // flush
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [PIX_W-1:0]       m_tdata;           // red, green, blue
    logic                   m_tlast;           // frame_last
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    image_3x3_smoothing_filter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // filter state as the bench sees it
    bit [PIX_W-1:0]        row_prev  [MAX_W];
    bit [PIX_W-1:0]        row_prev2 [MAX_W];
    bit [PIX_W-1:0]        win       [6];     // col*3 + row, col 0 oldest
    int unsigned           in_col, in_row, out_col, out_row;
    logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_RESET;
    logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;

    pixel_item_t pixel_q [$];
    smoothed_t   smoothed_q [$];
    pixel_item_t next_item;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned errors = 0;
    int unsigned cycle_count = 0;

    function automatic int unsigned eff_size(input int unsigned v, input int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic chan_t rand_chan();
        if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
        return chan_t'($urandom_range(255));
    endfunction

    function automatic pixel_t rand_pixel();
        return {rand_chan(), rand_chan(), rand_chan()};
    endfunction

    task automatic step_out(input int unsigned w);
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
    endtask

    // one accepted input item: update the stores, queue what comes out
    task automatic smooth_item(input pixel_t data, input logic flush);
        int unsigned    w, h, total, in_idx, out_idx, sum;
        int             k;
        bit [PIX_W-1:0] col [3];
        logic           interior;
        pixel_t         rgb;
        smoothed_t      res;
        w = eff_size(width_reg, MAX_W);
        h = eff_size(height_reg, MAX_H);
        total = w * h;
        in_idx = in_row * w + in_col;
        out_idx = out_row * w + out_col;
        if (!flush && in_idx < total) begin
            col[0] = row_prev2[in_col];
            col[1] = row_prev[in_col];
            col[2] = data;
            row_prev2[in_col] = col[1];
            row_prev[in_col] = data;
            if (in_idx >= w + 1) begin
                interior = out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w;
                rgb = '0;
                if (interior) begin
                    for (k = 0; k < 3; k++) begin
                        sum = win[0][8*k +: 8] + win[1][8*k +: 8] + win[2][8*k +: 8]
                            + col[0][8*k +: 8] + col[1][8*k +: 8] + col[2][8*k +: 8]
                            + win[3][8*k +: 8] + win[5][8*k +: 8];
                        rgb[8*k +: 8] = win[4][8*k +: 8] / 2 + sum / 16;
                    end
                end
                res = '{red: rgb[7:0], green: rgb[15:8], blue: rgb[23:16], last: 1'b0};
                smoothed_q.push_back(res);
                step_out(w);
            end
            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = col[0];
            win[4] = col[1];
            win[5] = col[2];
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end else if (in_idx >= total && out_idx < total) begin
            // drain: border pixels only
            res = '0;
            if (out_idx + 1 == total) begin
                res.last = 1'b1;
                in_col = 0;
                in_row = 0;
                out_col = 0;
                out_row = 0;
            end else begin
                step_out(w);
            end
            smoothed_q.push_back(res);
        end
    endtask

    task automatic apply_reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_IMAGE_WIDTH:  width_reg = data[WIDTH_REG_W-1:0];
            CFG_IMAGE_HEIGHT: height_reg = data[HEIGHT_REG_W-1:0];
            default: return;
        endcase
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // source side
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) smooth_item(s_tdata, s_tuser);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item = pixel_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_item.data;
                s_tuser  <= next_item.flush;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // sink side, register writes and watchdog
    always @(posedge aclk) begin
        smoothed_t exp_px;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
        if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
        if (aresetn && m_tvalid && m_tready) begin
            if (smoothed_q.size() == 0) begin
                $display("%0t: unexpected item, expected none, got data %h last %b",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                exp_px = smoothed_q.pop_front();
                check_field("red", exp_px.red, m_tdata[CH_W-1:0]);
                check_field("green", exp_px.green, m_tdata[2*CH_W-1:CH_W]);
                check_field("blue", exp_px.blue, m_tdata[3*CH_W-1:2*CH_W]);
                check_field("frame_last", exp_px.last, m_tlast);
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic set_idling(input idling_t mode);
        case (mode)
            IDLE_RX_HEAVY: begin
                send_idle_pct = 35;
                recv_idle_pct = 86;
            end
            IDLE_TX_HEAVY: begin
                send_idle_pct = 86;
                recv_idle_pct = 35;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    task automatic queue_item(input pixel_t data, input logic flush);
        pixel_q.push_back('{data: data, flush: flush});
    endtask

    // everything sent and received, then let the pipeline settle
    task automatic wait_idle();
        do @(negedge aclk);
        while (pixel_q.size() != 0 || s_tvalid || smoothed_q.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned work_items, w, h, n, cut, i;
        logic        wr_w, wr_h;
        idling_t     mode;

        work_items = 0;
        set_idling(IDLE_RX_HEAVY);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // default 640 x 480: the leading pixels of the first row come out, all border
        @(negedge aclk);
        for (i = 0; i < 650; i++) queue_item(rand_pixel(), 1'b0);
        wait_idle();
        // spare indexes must neither take effect nor restart the frame
        write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
        @(negedge aclk);
        for (i = 0; i < 8; i++) queue_item(rand_pixel(), 1'b0);

        // 4 x 4 frame with saturated channels, early flush, pixel as drain
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, 13'd4);
        write_reg(CFG_IMAGE_HEIGHT, 13'd4);
        @(negedge aclk);
        for (i = 0; i < 16; i++) begin
            if (i == 5) queue_item(rand_pixel(), 1'b1);
            queue_item({i[0] ? 8'hFF : 8'h00, 8'h00, i < 12 ? 8'hFF : 8'h00}, 1'b0);
        end
        queue_item(rand_pixel(), 1'b0);
        for (i = 0; i < 4; i++) queue_item(rand_pixel(), 1'b1);
        queue_item(rand_pixel(), 1'b1);   // new frame not started: dropped

        // random frames
        while (work_items < RANDOM_ITEMS) begin
            mode = work_items < RANDOM_ITEMS / 3 ? IDLE_RX_HEAVY :
                   work_items < 2 * RANDOM_ITEMS / 3 ? IDLE_TX_HEAVY : IDLE_NONE;
            wr_w = $urandom_range(1);
            wr_h = $urandom_range(1);
            if (wr_w || wr_h) begin
                wait_idle();
                if (wr_w) begin
                    w = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(12);
                    // bits above the register width are dropped
                    write_reg(CFG_IMAGE_WIDTH, {2'($urandom_range(3)), 11'(w)});
                end
                if (wr_h) write_reg(CFG_IMAGE_HEIGHT, 13'($urandom_range(8)));
            end
            @(negedge aclk);
            set_idling(mode);
            w = eff_size(width_reg, MAX_W);
            h = eff_size(height_reg, MAX_H);
            n = w * h;
            cut = ($urandom_range(5) == 0) ? $urandom_range(n) : n;
            for (i = 0; i < cut; i++) begin
                if ($urandom_range(19) == 0) queue_item(rand_pixel(), 1'b1);
                queue_item(rand_pixel(), 1'b0);
            end
            if (cut == n) begin
                for (i = 0; i <= w; i++)
                    queue_item(rand_pixel(), $urandom_range(7) != 0);
                work_items += w + 1;
            end
            work_items += cut;
        end

        // widest and tallest settings, clamped; only the top row and a few
        // pixels of the next are sent
        wait_idle();
        set_idling(IDLE_NONE);
        write_reg(CFG_IMAGE_WIDTH, 13'h1FFF);
        write_reg(CFG_IMAGE_HEIGHT, 13'h1FFF);
        @(negedge aclk);
        for (i = 0; i < MAX_W + 3; i++) queue_item(rand_pixel(), 1'b0);

        // zero sizes act as a single pixel frame
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, 13'd0);
        write_reg(CFG_IMAGE_HEIGHT, 13'd0);
        @(negedge aclk);
        queue_item(rand_pixel(), 1'b0);
        queue_item(rand_pixel(), 1'b1);
        queue_item(rand_pixel(), 1'b1);

        wait_idle();
        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule

/* image_3x3_smoothing_filter.f */
rtl/core/isf_pkg.sv
rtl/core/isf_line_store.sv
rtl/core/image_3x3_smoothing_filter.sv
rtl/core/isf_checker.sv
bench/tb.sv
